FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define STQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define STQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/stq_pkg.sv
package stq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 32;
   localparam int TIME_W      = 48;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int OCNT_W      = 7;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [OCNT_W-1:0]   ocnt_type;
   typedef logic [2:0]          emit_type;

   localparam mode_type MODE_INSERT  = 2'd0;
   localparam mode_type MODE_REMOVE  = 2'd1;
   localparam mode_type MODE_RUN     = 2'd2;
   localparam mode_type MODE_RUN_ALL = 2'd3;

   localparam status_type ST_INSERTED = 3'd0;
   localparam status_type ST_PRESENT  = 3'd1;
   localparam status_type ST_FULL     = 3'd2;
   localparam status_type ST_REMOVED  = 3'd3;
   localparam status_type ST_NOTFOUND = 3'd4;
   localparam status_type ST_EXPIRED  = 3'd5;
   localparam status_type ST_NONEDUE  = 3'd6;

   localparam emit_type EMIT_NONE     = 3'd0;
   localparam emit_type EMIT_PRESENT  = 3'd1;
   localparam emit_type EMIT_FULL     = 3'd2;
   localparam emit_type EMIT_INSERTED = 3'd3;
   localparam emit_type EMIT_REMOVE   = 3'd4;
   localparam emit_type EMIT_PEND     = 3'd5;
   localparam emit_type EMIT_NONEDUE  = 3'd6;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [ID_W-1:0]   item_id;
   } entry_type;

   typedef struct packed {
      logic     accept;
      logic     scan_step;
      logic     shift_init;
      logic     shift_step;
      logic     ins_write;
      logic     rem_finish;
      logic     run_read;
      logic     run_pop;
      emit_type emit;
      logic     emit_last;
   } ctl_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     scan_done;
      logic     shift_done;
      logic     dup_block;
      logic     full;
      logic     empty;
      logic     head_due;
      logic     pend_valid;
      logic     out_free;
   } ctl_stat_type;

endpackage

FILE: hdl/stq_req_if.sv
interface stq_req_if import stq_pkg::*; ();
   logic              valid;
   logic              ready;
   mode_type          mode;
   logic [ID_W-1:0]   item_id;
   logic [TIME_W-1:0] deadline;
   logic [TIME_W-1:0] now_time;

   modport source (output valid, output mode, output item_id, output deadline,
                   output now_time, input ready);
   modport sink (input valid, input mode, input item_id, input deadline,
                 input now_time, output ready);
endinterface

FILE: hdl/stq_rsp_if.sv
interface stq_rsp_if import stq_pkg::*; ();
   logic            valid;
   logic            ready;
   status_type      status;
   logic [ID_W-1:0] out_id;
   ocnt_type        matched;
   ocnt_type        occupancy;
   logic            last;

   modport source (output valid, output status, output out_id, output matched,
                   output occupancy, output last, input ready);
   modport sink (input valid, input status, input out_id, input matched,
                 input occupancy, input last, output ready);
endinterface

FILE: hdl/stq_csr_if.sv
interface stq_csr_if;
   logic valid;
   logic ready;
   logic allow_duplicates;

   modport source (output valid, output allow_duplicates, input ready);
   modport sink (input valid, input allow_duplicates, output ready);
endinterface

FILE: hdl/sorted_timer_queue_top.sv
// Insert: scans the N entries queued, shifts the later ones up, then writes.
// Remove: one scan that compacts the rest. Run: reads and checks each due entry.
// The entry store has a single read port, so scan and shift steps take one entry per cycle.
// The next request is taken once the previous one's last result is registered.
// Synchronous reset empties the queue and clears the run-all flag and allow_duplicates;
// the entry store itself is not cleared.
module sorted_timer_queue_top import stq_pkg::*; (
   input logic        clock,
   input logic        reset,
   stq_req_if.sink    req_ch,
   stq_rsp_if.source  rsp_ch,
   stq_csr_if.sink    csr_ch
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;
   logic         req_ready;

   assign req_ch.ready = req_ready;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   stq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_mode     (req_ch.mode),
      .req_item_id  (req_ch.item_id),
      .req_deadline (req_ch.deadline),
      .req_now_time (req_ch.now_time),
      .csr_ch       (csr_ch),
      .rsp_ch       (rsp_ch)
   );

endmodule

FILE: hdl/stq_ctrl.sv
`include "assert_macros.svh"

module stq_ctrl import stq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  mode_type     req_mode,
   output logic         req_ready,
   output ctl_cmd_type  cmd,
   input  ctl_stat_type stat
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_DECIDE   = 3'd2;
   localparam logic [2:0] S_SHIFT    = 3'd3;
   localparam logic [2:0] S_INS_WR   = 3'd4;
   localparam logic [2:0] S_REM_DONE = 3'd5;
   localparam logic [2:0] S_RUN_RD   = 3'd6;
   localparam logic [2:0] S_RUN_CHK  = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      cmd.emit  = EMIT_NONE;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_mode inside {MODE_INSERT, MODE_REMOVE}) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RUN_RD;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = (stat.mode == MODE_INSERT) ? S_DECIDE : S_REM_DONE;
            end
         end
         S_DECIDE: begin
            if (stat.dup_block) begin
               if (stat.out_free) begin
                  cmd.emit      = EMIT_PRESENT;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (stat.full) begin
               if (stat.out_free) begin
                  cmd.emit      = EMIT_FULL;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) begin
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            if (stat.out_free) begin
               cmd.ins_write = 1'b1;
               cmd.emit      = EMIT_INSERTED;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_REM_DONE: begin
            if (stat.out_free) begin
               cmd.rem_finish = 1'b1;
               cmd.emit       = EMIT_REMOVE;
               cmd.emit_last  = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_RUN_RD: begin
            if (stat.empty) begin
               if (stat.out_free) begin
                  cmd.emit      = stat.pend_valid ? EMIT_PEND : EMIT_NONEDUE;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.run_read = 1'b1;
               state_in     = S_RUN_CHK;
            end
         end
         S_RUN_CHK: begin
            if (!stat.head_due) begin
               if (stat.out_free) begin
                  cmd.emit      = stat.pend_valid ? EMIT_PEND : EMIT_NONEDUE;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (!stat.pend_valid) begin
               cmd.run_pop = 1'b1;
               state_in    = S_RUN_RD;
            end else if (stat.out_free) begin
               cmd.emit    = EMIT_PEND;
               cmd.run_pop = 1'b1;
               state_in    = S_RUN_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `STQ_ASSERT(a_accept_leaves_idle, req_valid && req_ready |=> state_ff != S_IDLE, "accepted request did not start an operation")

endmodule

FILE: hdl/stq_datapath.sv
`include "assert_macros.svh"

module stq_datapath import stq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctl_cmd_type       cmd,
   output ctl_stat_type      stat,
   input  mode_type          req_mode,
   input  logic [ID_W-1:0]   req_item_id,
   input  logic [TIME_W-1:0] req_deadline,
   input  logic [TIME_W-1:0] req_now_time,
   stq_csr_if.sink           csr_ch,
   stq_rsp_if.source         rsp_ch
);

   entry_type         mem_ff [QUEUE_DEPTH];
   entry_type         rdata_ff;
   logic              mem_we;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_waddr;
   logic [IDX_W-1:0]  mem_raddr;
   entry_type         mem_wdata;

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              drain_all_ff, drain_all_in;
   logic              allow_dup_ff, allow_dup_in;

   mode_type          mode_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] deadline_ff;
   logic [TIME_W-1:0] now_ff;

   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic [CNT_W-1:0]  matched_ff, matched_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]  sh_ff, sh_in;
   logic [CNT_W-1:0]  sh_dst_ff, sh_dst_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic              sh_valid_ff, sh_valid_in;
   logic              pos_found_ff, pos_found_in;
   logic              dup_ff, dup_in;

   logic              pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic [CNT_W-1:0]  pend_occ_ff, pend_occ_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   ocnt_type          rsp_matched_ff, rsp_matched_in;
   ocnt_type          rsp_occ_ff, rsp_occ_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;

   // Maps a position counted from the head to a slot of the circular store.
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
      if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      drain_all_in   = drain_all_ff;
      allow_dup_in   = allow_dup_ff;
      rd_in          = rd_ff;
      wr_in          = wr_ff;
      matched_in     = matched_ff;
      pos_in         = pos_ff;
      cmp_idx_in     = cmp_idx_ff;
      sh_in          = sh_ff;
      sh_dst_in      = sh_dst_ff;
      cmp_valid_in   = cmp_valid_ff;
      sh_valid_in    = sh_valid_ff;
      pos_found_in   = pos_found_ff;
      dup_in         = dup_ff;
      pend_valid_in  = pend_valid_ff;
      pend_id_in     = pend_id_ff;
      pend_occ_in    = pend_occ_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = head_ff;
      mem_raddr      = head_ff;
      mem_wdata      = rdata_ff;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_ch.valid) begin
         allow_dup_in = csr_ch.allow_duplicates;
      end

      if (cmd.accept) begin
         rd_in        = '0;
         wr_in        = '0;
         matched_in   = '0;
         dup_in       = 1'b0;
         pos_found_in = 1'b0;
         pos_in       = count_ff;
         cmp_valid_in = 1'b0;
         if (req_mode == MODE_RUN_ALL) begin
            drain_all_in = 1'b1;
         end
      end

      if (cmd.scan_step) begin
         cmp_valid_in = (rd_ff != count_ff);
         cmp_idx_in   = rd_ff;
         if (rd_ff != count_ff) begin
            mem_re    = 1'b1;
            mem_raddr = phys(head_ff, rd_ff);
            rd_in     = rd_ff + CNT_W'(1);
         end
         if (cmp_valid_ff) begin
            if (mode_ff == MODE_INSERT) begin
               if (rdata_ff.item_id == id_ff) begin
                  dup_in = 1'b1;
               end
               if (!pos_found_ff && deadline_ff <= rdata_ff.deadline) begin
                  pos_found_in = 1'b1;
                  pos_in       = cmp_idx_ff;
               end
            end else if (rdata_ff.item_id == id_ff && (allow_dup_ff || matched_ff == '0)) begin
               matched_in = matched_ff + CNT_W'(1);
            end else begin
               mem_we    = 1'b1;
               mem_waddr = phys(head_ff, wr_ff);
               wr_in     = wr_ff + CNT_W'(1);
            end
         end
      end

      if (cmd.shift_init) begin
         sh_in       = count_ff;
         sh_valid_in = 1'b0;
      end

      if (cmd.shift_step) begin
         sh_valid_in = (sh_ff != pos_ff);
         sh_dst_in   = sh_ff;
         if (sh_ff != pos_ff) begin
            mem_re    = 1'b1;
            mem_raddr = phys(head_ff, sh_ff - CNT_W'(1));
            sh_in     = sh_ff - CNT_W'(1);
         end
         if (sh_valid_ff) begin
            mem_we    = 1'b1;
            mem_waddr = phys(head_ff, sh_dst_ff);
         end
      end

      if (cmd.ins_write) begin
         mem_we             = 1'b1;
         mem_waddr          = phys(head_ff, pos_ff);
         mem_wdata.deadline = deadline_ff;
         mem_wdata.item_id  = id_ff;
         count_in           = count_ff + CNT_W'(1);
      end

      if (cmd.rem_finish) begin
         count_in = count_ff - matched_ff;
      end

      if (cmd.run_read) begin
         mem_re    = 1'b1;
         mem_raddr = head_ff;
      end

      if (cmd.run_pop) begin
         pend_valid_in = 1'b1;
         pend_id_in    = rdata_ff.item_id;
         pend_occ_in   = count_ff - CNT_W'(1);
         count_in      = count_ff - CNT_W'(1);
         head_in       = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
      end

      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in   = 1'b1;
         rsp_last_in    = cmd.emit_last;
         rsp_status_in  = ST_NONEDUE;
         rsp_id_in      = '0;
         rsp_matched_in = '0;
         rsp_occ_in     = ocnt_type'(count_ff);
         case (cmd.emit)
            EMIT_PRESENT: begin
               rsp_status_in = ST_PRESENT;
               rsp_id_in     = id_ff;
            end
            EMIT_FULL: begin
               rsp_status_in = ST_FULL;
               rsp_id_in     = id_ff;
            end
            EMIT_INSERTED: begin
               rsp_status_in = ST_INSERTED;
               rsp_id_in     = id_ff;
               rsp_occ_in    = ocnt_type'(count_ff + CNT_W'(1));
            end
            EMIT_REMOVE: begin
               rsp_status_in  = (matched_ff != '0) ? ST_REMOVED : ST_NOTFOUND;
               rsp_matched_in = ocnt_type'(matched_ff);
               rsp_occ_in     = ocnt_type'(count_ff - matched_ff);
            end
            EMIT_PEND: begin
               rsp_status_in = ST_EXPIRED;
               rsp_id_in     = pend_id_ff;
               rsp_occ_in    = ocnt_type'(pend_occ_ff);
               if (!cmd.run_pop) begin
                  pend_valid_in = 1'b0;
               end
            end
            default: begin
               rsp_status_in = ST_NONEDUE;
            end
         endcase
      end
   end

   always_comb begin
      stat.mode       = mode_ff;
      stat.scan_done  = (rd_ff == count_ff) && !cmp_valid_ff;
      stat.shift_done = (sh_ff == pos_ff) && !sh_valid_ff;
      stat.dup_block  = dup_ff && !allow_dup_ff;
      stat.full       = (count_ff == CNT_W'(QUEUE_DEPTH));
      stat.empty      = (count_ff == '0);
      stat.head_due   = drain_all_ff || (rdata_ff.deadline <= now_ff);
      stat.pend_valid = pend_valid_ff;
      stat.out_free   = out_free;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff     <= req_mode;
         id_ff       <= req_item_id;
         deadline_ff <= req_deadline;
         now_ff      <= req_now_time;
      end
      pos_ff         <= pos_in;
      cmp_idx_ff     <= cmp_idx_in;
      sh_dst_ff      <= sh_dst_in;
      pend_id_ff     <= pend_id_in;
      pend_occ_ff    <= pend_occ_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         drain_all_ff  <= 1'b0;
         allow_dup_ff  <= 1'b0;
         rd_ff         <= '0;
         wr_ff         <= '0;
         matched_ff    <= '0;
         sh_ff         <= '0;
         cmp_valid_ff  <= 1'b0;
         sh_valid_ff   <= 1'b0;
         pos_found_ff  <= 1'b0;
         dup_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         drain_all_ff  <= drain_all_in;
         allow_dup_ff  <= allow_dup_in;
         rd_ff         <= rd_in;
         wr_ff         <= wr_in;
         matched_ff    <= matched_in;
         sh_ff         <= sh_in;
         cmp_valid_ff  <= cmp_valid_in;
         sh_valid_ff   <= sh_valid_in;
         pos_found_ff  <= pos_found_in;
         dup_ff        <= dup_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.out_id    = rsp_id_ff;
   assign rsp_ch.matched   = rsp_matched_ff;
   assign rsp_ch.occupancy = rsp_occ_ff;
   assign rsp_ch.last      = rsp_last_ff;

   `STQ_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
   `STQ_ASSERT(a_emit_when_free, cmd.emit != EMIT_NONE |-> out_free, "result over a held result")
   `STQ_ASSERT(a_compact_order, wr_ff <= rd_ff && matched_ff <= rd_ff, "compaction overran scan")

endmodule
